@@ sv/utu_pkg.sv @@
// utu_pkg: shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; imported by the decoder, the output buffer and the top level
`default_nettype none

package utu_pkg;

  localparam int unsigned MaxUnits = 4;
  localparam int unsigned CountW   = $clog2(MaxUnits + 1);
  localparam int unsigned IdxW     = $clog2(MaxUnits);
  localparam int unsigned ValueW   = 21;

  localparam logic [15:0] ReplacementUnit = 16'hFFFD;
  localparam logic [7:0]  ContMask        = 8'hC0;
  localparam logic [7:0]  ContTag         = 8'h80;

  localparam logic [ValueW-1:0] MinLen2       = 21'h00_0080;
  localparam logic [ValueW-1:0] MinLen3       = 21'h00_0800;
  localparam logic [ValueW-1:0] MinLen4       = 21'h01_0000;
  localparam logic [ValueW-1:0] MaxScalar     = 21'h10_FFFF;
  localparam logic [ValueW-1:0] SurrogateLow  = 21'h00_D800;
  localparam logic [ValueW-1:0] SurrogateHigh = 21'h00_DFFF;
  localparam logic [ValueW-1:0] PlaneBase     = 21'h01_0000;
  localparam logic [15:0]       HighSurrBase  = 16'hD800;
  localparam logic [15:0]       LowSurrBase   = 16'hDC00;
  localparam logic [9:0]        TenBitMask    = 10'h3FF;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  // units produced by one byte, filled from index 0
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [CountW-1:0]         count;
    logic                      eos;
  } result_t;

endpackage

`default_nettype wire

@@ sv/utu_if.sv @@
// utu_if: valid/ready channel interfaces for byte input and code unit output
// no dependencies
`default_nettype none

interface utu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] input_byte;
  logic       end_of_string;

  modport source (output valid, output input_byte, output end_of_string, input ready);
  modport sink   (input valid, input input_byte, input end_of_string, output ready);
endinterface

interface utu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_of_run;
  logic        string_done;

  modport source (output valid, output code_unit, output last_of_run, output string_done,
                  input ready);
  modport sink   (input valid, input code_unit, input last_of_run, input string_done,
                  output ready);
endinterface

`default_nettype wire

@@ sv/utu_decode.sv @@
// utu_decode: sequence state and per-byte decode into up to four code units
// depends on utu_pkg
`default_nettype none

module utu_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic [7:0]    input_byte,
  input  wire logic          end_of_string,
  output utu_pkg::result_t   res
);
  import utu_pkg::*;

  logic [2:0]        exp_len, exp_len_next;
  logic [1:0]        seen, seen_next;
  logic [ValueW-1:0] partial, partial_next;

  logic              open_seq;
  logic              is_cont;
  logic [2:0]        seen_inc;
  logic [ValueW-1:0] cat;
  logic [ValueW-1:0] minimum;
  logic [ValueW-1:0] offset;
  logic              cp_ok;
  logic [15:0]       hi_unit, lo_unit;
  logic [CountW-1:0] pre;
  logic              place_byte;

  assign open_seq = (exp_len != LenNone);
  assign is_cont  = ((input_byte & ContMask) == ContTag);
  assign seen_inc = {1'b0, seen} + 3'd1;
  assign cat      = {partial[ValueW-7:0], input_byte[5:0]};

  always_comb begin
    unique case (exp_len)
      LenTwo:   minimum = MinLen2;
      LenThree: minimum = MinLen3;
      default:  minimum = MinLen4;
    endcase
  end

  assign cp_ok = (cat >= minimum) && (cat <= MaxScalar) &&
                 !((cat >= SurrogateLow) && (cat <= SurrogateHigh));

  assign offset  = cat - PlaneBase;
  assign hi_unit = HighSurrBase | {6'd0, offset[19:10]};
  assign lo_unit = LowSurrBase | {6'd0, offset[9:0] & TenBitMask};

  always_comb begin
    res.units    = {MaxUnits{ReplacementUnit}};
    res.count    = '0;
    res.eos      = end_of_string;
    pre          = '0;
    place_byte   = 1'b0;
    exp_len_next = exp_len;
    seen_next    = seen;
    partial_next = partial;

    if (open_seq && is_cont) begin
      if (seen_inc == exp_len) begin
        exp_len_next = LenNone;
        seen_next    = '0;
        partial_next = '0;
        if (!cp_ok) begin
          res.count = CountW'(exp_len);
        end else if (cat[ValueW-1:16] == '0) begin
          res.units[0] = cat[15:0];
          res.count    = CountW'(1);
        end else begin
          res.units[0] = hi_unit;
          res.units[1] = lo_unit;
          res.count    = CountW'(2);
        end
      end else begin
        seen_next    = seen_inc[1:0];
        partial_next = cat;
        if (end_of_string) begin
          // truncated at end of string: one replacement per byte held
          res.count    = CountW'(seen_inc);
          exp_len_next = LenNone;
          seen_next    = '0;
          partial_next = '0;
        end
      end
    end else begin
      // broken sequence flushes first, then the byte is decoded afresh
      if (open_seq) begin
        pre = CountW'(seen);
      end
      res.count    = pre;
      exp_len_next = LenNone;
      seen_next    = '0;
      partial_next = '0;
      case (input_byte) inside
        [8'h00:8'h7F]: begin
          place_byte = 1'b1;
          res.count  = pre + CountW'(1);
        end
        [8'hC2:8'hDF]: begin
          exp_len_next = LenTwo;
          seen_next    = 2'd1;
          partial_next = {16'd0, input_byte[4:0]};
        end
        [8'hE0:8'hEF]: begin
          exp_len_next = LenThree;
          seen_next    = 2'd1;
          partial_next = {17'd0, input_byte[3:0]};
        end
        [8'hF0:8'hF4]: begin
          exp_len_next = LenFour;
          seen_next    = 2'd1;
          partial_next = {18'd0, input_byte[2:0]};
        end
        default: begin
          res.count = pre + CountW'(1);
        end
      endcase
      if (end_of_string && (exp_len_next != LenNone)) begin
        res.count    = pre + CountW'(1);
        exp_len_next = LenNone;
        seen_next    = '0;
        partial_next = '0;
      end
      for (int i = 0; i < MaxUnits; i++) begin
        if (place_byte && (pre[IdxW-1:0] == IdxW'(i))) begin
          res.units[i] = {8'h00, input_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= LenNone;
      seen    <= '0;
      partial <= '0;
    end else if (advance) begin
      exp_len <= exp_len_next;
      seen    <= seen_next;
      partial <= partial_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/utu_burst.sv @@
// utu_burst: result register holding one byte's code units, drained one word a cycle while the output is ready
// depends on utu_pkg, utu_if
`default_nettype none

module utu_burst (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire utu_pkg::result_t res,
  output logic                  free,
  utu_out_if.source             unit_stream
);
  import utu_pkg::*;

  logic [MaxUnits-1:0][15:0] units;
  logic [CountW-1:0]         count;
  logic [IdxW-1:0]           idx;
  logic                      eos;
  logic                      valid;
  logic                      last;

  assign last = ({1'b0, idx} == (count - CountW'(1)));
  assign free = !valid || (unit_stream.ready && last);

  assign unit_stream.valid       = valid;
  assign unit_stream.code_unit   = units[idx];
  assign unit_stream.last_of_run = last;
  assign unit_stream.string_done = last && eos;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && unit_stream.ready) begin
      if (last) begin
        valid <= 1'b0;
        idx   <= '0;
      end else begin
        idx <= idx + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      units <= res.units;
      count <= res.count;
      eos   <= res.eos;
    end
  end

endmodule

`default_nettype wire

@@ sv/utf8_to_utf16_transcoder.sv @@
// utf8_to_utf16_transcoder: one utf-8 byte in per cycle when not held by the result register, utf-16 code units out
// a byte passes the input register, then the result register, before its first code unit appears
// one byte per cycle while the result register is free; a byte yielding units holds it until its last unit is taken
// bytes that yield no unit (mid sequence) pass through without using the result register
// reset: synchronous, active high; clears the open sequence and both valid flags
// depends on utu_pkg, utu_if, utu_decode, utu_burst
`default_nettype none

module utf8_to_utf16_transcoder (
  input  wire logic  clk,
  input  wire logic  rst,
  utu_in_if.sink     byte_stream,
  utu_out_if.source  unit_stream
);
  import utu_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       advance;
  logic       burst_free;
  result_t    res;

  // a byte moves on if it yields nothing or the result register is free or frees up this cycle
  assign advance = in_valid && ((res.count == '0) || burst_free);
  assign byte_stream.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_stream.valid && byte_stream.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      in_byte <= byte_stream.input_byte;
      in_eos  <= byte_stream.end_of_string;
    end
  end

  utu_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .input_byte    (in_byte),
    .end_of_string (in_eos),
    .res           (res)
  );

  utu_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && (res.count != '0)),
    .res         (res),
    .free        (burst_free),
    .unit_stream (unit_stream)
  );

endmodule

`default_nettype wire
